FILE: rtl/tcd_pkg.sv
package tcd_pkg;

    localparam int SAMPLES  = 4;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 48;
    localparam int RATE_W   = 30;
    localparam int TIME_W   = 63;
    localparam int PROD_W   = 62;

    // speed bands, open intervals
    localparam logic [PERIOD_W-1:0] BAND_FAST_LO = 16'd23320;
    localparam logic [PERIOD_W-1:0] BAND_FAST_HI = 16'd28566;
    localparam logic [PERIOD_W-1:0] BAND_MID_LO  = 16'd16461;
    localparam logic [PERIOD_W-1:0] BAND_MID_HI  = 16'd20161;
    localparam logic [PERIOD_W-1:0] BAND_SLOW_LO = 16'd10974;
    localparam logic [PERIOD_W-1:0] BAND_SLOW_HI = 16'd13441;

    localparam logic [PERIOD_W-1:0] FRACT_MAX = 16'hFFFF;

    // divider: quotient bits per pipeline stage
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = PERIOD_W / DIV_BITS;

    // unit rates, ticks are 2^31 per second
    localparam logic [RATE_W-1:0] RATE_NS = 30'd1000000000;
    localparam logic [RATE_W-1:0] RATE_US = 30'd1000000;
    localparam logic [RATE_W-1:0] RATE_MS = 30'd1000;

    localparam logic [1:0] UNIT_NS = 2'd0;
    localparam logic [1:0] UNIT_US = 2'd1;
    localparam logic [1:0] UNIT_MS = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHECK_ENABLE = 1'b0;
    localparam logic CFG_TIME_UNIT    = 1'b1;

    typedef struct packed {
        logic       check_enable;
        logic [1:0] time_unit;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [PERIOD_W-1:0] cur;
        logic [PERIOD_W-1:0] maxp;
        logic                hist_valid;
    } t_cls;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic                hist_valid;
        logic                cap;
        logic [PERIOD_W-1:0] d;
        logic [PERIOD_W-1:0] rem;
        logic [PERIOD_W-1:0] q;
    } t_div;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [PERIOD_W-1:0] fract;
        logic                hist_valid;
    } t_frac;

    typedef struct packed {
        logic [63:0]       ticks;
        logic [RATE_W-1:0] rate;
        logic              hist_valid;
    } t_scl_a;

    typedef struct packed {
        logic [63:0]       ticks;
        logic [PROD_W-1:0] plo;
        logic [PROD_W-1:0] phi;
        logic              hist_valid;
    } t_scl_b;

endpackage

FILE: rtl/timestamp_counter_decode_top.sv
// pipeline: 1 classify, 8 divide and 3 scale stages from input transfer to result
// throughput: one snapshot per cycle unless the output stalls; each stage
// holds one item and moves on when the stage after it is empty or moving,
// so bubbles close up under stall; reset: synchronous active-low i_rst_n
// empties every stage, check_enable returns to 1 and time_unit to nanoseconds
module timestamp_counter_decode_top
    import tcd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [1:0]   i_cfg_data,
    // snapshot input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] counter_low_word, [127:64] counter_high_word
    input  logic [127:0] s_axis_tdata,
    // decoded result
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] ticks_fixed, [126:64] time_value, [127] zero
    output logic [127:0] m_axis_tdata,
    // [0] history_valid
    output logic         m_axis_tuser
);

    t_cfg              r_cfg;

    // classify to divider
    logic              cls_valid, cls_ready;
    t_cls              cls_data;

    // divider to scale
    logic              div_valid, div_ready;
    t_frac             div_data;

    logic [63:0]       ticks;
    logic [TIME_W-1:0] time_val;

    // register writes must only arrive while the pipeline is empty; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enable <= 1'b1;
            r_cfg.time_unit    <= UNIT_NS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHECK_ENABLE: r_cfg.check_enable <= i_cfg_data[0];
                CFG_TIME_UNIT:    r_cfg.time_unit    <= i_cfg_data;
                default:          r_cfg.check_enable <= r_cfg.check_enable;
            endcase
        end
    end

    // band check and largest history period
    tcd_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_low_word  (s_axis_tdata[63:0]),
        .i_high_word (s_axis_tdata[127:64]),
        .o_valid     (cls_valid),
        .i_ready     (cls_ready),
        .o_data      (cls_data)
    );

    // fraction = current * 65536 / largest, saturated, two quotient bits per stage
    tcd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .o_ready (cls_ready),
        .i_data  (cls_data),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_data  (div_data)
    );

    // ticks assembly and unit conversion, last stage is the output register
    tcd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (div_valid),
        .o_ready      (div_ready),
        .i_data       (div_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_ticks      (ticks),
        .o_time       (time_val),
        .o_hist_valid (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, time_val, ticks};

endmodule

FILE: rtl/tcd_classify.sv
module tcd_classify
    import tcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_low_word,
    input  logic [63:0] i_high_word,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cls        o_data
);

    logic [PERIOD_W-1:0] p [SAMPLES];
    logic [SAMPLES-1:0]  is_fast, is_mid, is_slow;
    logic [PERIOD_W-1:0] max01, max23, max_all;
    logic                en;
    logic                r_v;
    t_cls                r_d, n_d;

    always_comb begin
        for (int k = 0; k < SAMPLES; k++) begin
            p[k]       = i_low_word[PERIOD_W*k +: PERIOD_W];
            is_fast[k] = (p[k] > BAND_FAST_LO) && (p[k] < BAND_FAST_HI);
            is_mid[k]  = (p[k] > BAND_MID_LO) && (p[k] < BAND_MID_HI);
            is_slow[k] = (p[k] > BAND_SLOW_LO) && (p[k] < BAND_SLOW_HI);
        end
    end

    // max over the four samples, floor of one
    assign max01   = (p[0] > p[1]) ? p[0] : p[1];
    assign max23   = (p[2] > p[3]) ? p[2] : p[3];
    assign max_all = (max01 > max23) ? max01 : max23;

    always_comb begin
        n_d.count      = i_high_word[63:PERIOD_W];
        n_d.cur        = i_high_word[PERIOD_W-1:0];
        n_d.maxp       = (max_all == '0) ? PERIOD_W'(1) : max_all;
        // bands are exclusive: every sample banded and not all three bands used
        n_d.hist_valid = (&(is_fast | is_mid | is_slow)) &&
                         !((|is_fast) && (|is_mid) && (|is_slow));
    end

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d <= n_d;
        end
    end

endmodule

FILE: rtl/tcd_divider.sv
module tcd_divider
    import tcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cls  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_frac o_data
);

    logic [DIV_STAGES:0]   en;
    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] v_src;
    t_div                  r_st  [DIV_STAGES];
    t_div                  n_st  [DIV_STAGES];
    t_div                  src   [DIV_STAGES];
    t_div                  init;

    // quotient can only fit 16 bits when current period is below the divisor
    always_comb begin
        init.count      = i_data.count;
        init.hist_valid = i_data.hist_valid;
        init.cap        = (i_data.cur >= i_data.maxp);
        init.d          = i_data.maxp;
        init.rem        = init.cap ? '0 : i_data.cur;
        init.q          = '0;
    end

    always_comb begin
        logic [PERIOD_W:0] sh;
        t_div              w;
        for (int s = 0; s < DIV_STAGES; s++) begin
            src[s]   = (s == 0) ? init : r_st[(s == 0) ? 0 : s - 1];
            v_src[s] = (s == 0) ? i_valid : r_v[(s == 0) ? 0 : s - 1];
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            w = src[s];
            // restoring steps, shifting in zeros
            for (int b = 0; b < DIV_BITS; b++) begin
                sh = {w.rem, 1'b0};
                if (sh >= {1'b0, w.d}) begin
                    sh = sh - {1'b0, w.d};
                    w.q = {w.q[PERIOD_W-2:0], 1'b1};
                end else begin
                    w.q = {w.q[PERIOD_W-2:0], 1'b0};
                end
                w.rem = sh[PERIOD_W-1:0];
            end
            n_st[s] = w;
        end
    end

    always_comb begin
        en[DIV_STAGES] = i_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready          = en[0];
    assign o_valid          = r_v[DIV_STAGES-1];
    assign o_data.count      = r_st[DIV_STAGES-1].count;
    assign o_data.hist_valid = r_st[DIV_STAGES-1].hist_valid;
    assign o_data.fract      = r_st[DIV_STAGES-1].cap ? FRACT_MAX : r_st[DIV_STAGES-1].q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                if (en[s]) begin
                    r_v[s] <= v_src[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (en[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

endmodule

FILE: rtl/tcd_scale.sv
module tcd_scale
    import tcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_frac             i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [63:0]       o_ticks,
    output logic [TIME_W-1:0] o_time,
    output logic              o_hist_valid
);

    logic [2:0]        r_v;
    logic [3:0]        en;
    t_scl_a            r_a, n_a;
    t_scl_b            r_b, n_b;
    logic [PROD_W-1:0] mid;
    logic [63:0]       r_ticks;
    logic [TIME_W-1:0] r_time;
    logic              r_hv;

    // stage a: checked zeroing and rate pick
    always_comb begin
        n_a.hist_valid = i_data.hist_valid;
        if (i_cfg.check_enable && !i_data.hist_valid) begin
            n_a.ticks = '0;
        end else begin
            n_a.ticks = {i_data.count, i_data.fract};
        end
        unique case (i_cfg.time_unit)
            UNIT_NS: n_a.rate = RATE_NS;
            UNIT_US: n_a.rate = RATE_US;
            UNIT_MS: n_a.rate = RATE_MS;
            default: n_a.rate = '0;
        endcase
    end

    // stage b: two 32x30 partial products
    always_comb begin
        n_b.ticks      = r_a.ticks;
        n_b.hist_valid = r_a.hist_valid;
        n_b.plo        = PROD_W'(r_a.ticks[31:0]) * PROD_W'(r_a.rate);
        n_b.phi        = PROD_W'(r_a.ticks[63:32]) * PROD_W'(r_a.rate);
    end

    // stage c: combine, keep product bits 93:31
    assign mid = r_b.phi + {32'b0, r_b.plo[PROD_W-1:32]};

    assign en[3] = i_ready;
    assign en[2] = !r_v[2] || en[3];
    assign en[1] = !r_v[1] || en[2];
    assign en[0] = !r_v[0] || en[1];

    assign o_ready      = en[0];
    assign o_valid      = r_v[2];
    assign o_ticks      = r_ticks;
    assign o_time       = r_time;
    assign o_hist_valid = r_hv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            if (en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (en[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a <= n_a;
        end
        if (en[1]) begin
            r_b <= n_b;
        end
        if (en[2]) begin
            r_ticks <= r_b.ticks;
            r_time  <= {mid[PROD_W-1:0], r_b.plo[31]};
            r_hv    <= r_b.hist_valid;
        end
    end

endmodule

FILE: rtl/tcd_checker.sv
module tcd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // zero ticks give zero time
    a_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[63:0] == 64'd0) |-> m_axis_tdata[126:64] == 63'd0)
        else $error("time value without ticks");

    // padding bit stays clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[127])
        else $error("pad bit set");

endmodule

bind timestamp_counter_decode_top tcd_checker u_tcd_checker (.*);

FILE: tb/tb_timestamp_counter_decode_top.sv
module tb_timestamp_counter_decode_top;
    import tcd_pkg::*;

    // clock period 8, reset held for RESET_CYCLES, SETTLE_CYCLES covers the pipeline plus margin
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 180;

    // time_unit code with no rate behind it
    localparam logic [1:0] UNIT_NONE = 2'd3;

    typedef enum logic [1:0] {SPEED_SLOW, SPEED_MID, SPEED_FAST, SPEED_NONE} t_speed;

    // one decoded snapshot as the block should report it
    typedef struct {
        logic [63:0] ticks;
        logic [62:0] scaled;
        logic        valid;
    } t_decode;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [1:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [63:0] counter_low_word, [127:64] counter_high_word
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [63:0] ticks_fixed, [126:64] time_value, [127] zero
    logic [127:0] m_axis_tdata;
    // [0] history_valid
    logic         m_axis_tuser;

    // shadow of the two registers, updated as they are written
    logic         cfg_check;
    logic [1:0]   cfg_unit;

    t_decode      pending_decodes[$];
    int           mismatch_count  = 0;
    int           snapshots_sent  = 0;
    int           results_checked = 0;
    int           config_phases   = 0;
    int           cycle_count     = 0;
    // when set, neither side inserts gaps or stalls
    bit           no_idle         = 1'b0;

    timestamp_counter_decode_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_decodes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // expected decode of one snapshot under the current register shadow
    function automatic t_decode decode_snapshot(input logic [63:0] lo_word,
                                                input logic [63:0] hi_word);
        t_decode     r;
        logic [15:0] p;
        logic [15:0] largest;
        int          n_fast;
        int          n_mid;
        int          n_slow;
        logic [31:0] fract;
        logic [31:0] rate;
        logic [95:0] prod;
        logic        ok;
        n_fast  = 0;
        n_mid   = 0;
        n_slow  = 0;
        largest = 16'd1;
        for (int k = 0; k < SAMPLES; k++) begin
            p = lo_word[16*k +: 16];
            if (p > BAND_FAST_LO && p < BAND_FAST_HI) n_fast++;
            if (p > BAND_MID_LO && p < BAND_MID_HI) n_mid++;
            if (p > BAND_SLOW_LO && p < BAND_SLOW_HI) n_slow++;
            if (p > largest) largest = p;
        end
        // every sample in a band, and no more than two bands in use
        ok = (n_fast + n_mid == 4 && n_slow == 0) ||
             (n_fast + n_slow == 4 && n_mid == 0) ||
             (n_mid + n_slow == 4 && n_fast == 0);
        fract = {hi_word[15:0], 16'd0} / {16'd0, largest};
        if (fract > 32'd65535) fract = 32'd65535;
        r.ticks = {hi_word[63:16], fract[15:0]};
        if (cfg_check && !ok) r.ticks = '0;
        case (cfg_unit)
            UNIT_NS: rate = 32'(RATE_NS);
            UNIT_US: rate = 32'(RATE_US);
            UNIT_MS: rate = 32'(RATE_MS);
            default: rate = '0;
        endcase
        // one second is 2^31 ticks
        prod     = 96'(r.ticks) * 96'(rate);
        r.scaled = prod[93:31];
        r.valid  = ok;
        return r;
    endfunction

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [63:0] history(input logic [15:0] p0, input logic [15:0] p1,
                                            input logic [15:0] p2, input logic [15:0] p3);
        return {p3, p2, p1, p0};
    endfunction

    function automatic logic [63:0] high_word(input logic [47:0] count,
                                              input logic [15:0] cur);
        return {count, cur};
    endfunction

    // one period drawn from a band, or from outside all of them
    function automatic logic [15:0] band_sample(input t_speed s);
        logic [15:0] lo_b;
        logic [15:0] hi_b;
        case (s)
            SPEED_FAST: begin
                lo_b = BAND_FAST_LO;
                hi_b = BAND_FAST_HI;
            end
            SPEED_MID: begin
                lo_b = BAND_MID_LO;
                hi_b = BAND_MID_HI;
            end
            SPEED_SLOW: begin
                lo_b = BAND_SLOW_LO;
                hi_b = BAND_SLOW_HI;
            end
            default: begin
                // gaps between bands, band limits themselves included
                case ($urandom_range(0, 4))
                    0: return 16'($urandom_range(0, BAND_SLOW_LO));
                    1: return 16'($urandom_range(BAND_SLOW_HI, BAND_MID_LO));
                    2: return 16'($urandom_range(BAND_MID_HI, BAND_FAST_LO));
                    3: return 16'($urandom_range(BAND_FAST_HI, 16'hFFFF));
                    default: return BAND_SLOW_HI;
                endcase
            end
        endcase
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? lo_b + 16'd1 : hi_b - 16'd1;
        return 16'($urandom_range(lo_b + 1, hi_b - 1));
    endfunction

    // mostly plausible histories, some with three bands or a stray sample, some noise
    function automatic logic [127:0] random_snapshot();
        t_speed      first;
        t_speed      second;
        logic [15:0] p [4];
        logic [47:0] count;
        logic [15:0] cur;
        int          kind;
        int          r;
        kind   = $urandom_range(0, 99);
        first  = t_speed'($urandom_range(0, 2));
        second = t_speed'($urandom_range(0, 2));
        for (int k = 0; k < 4; k++)
            p[k] = band_sample($urandom_range(0, 1) ? first : second);
        if (kind >= 70 && kind < 80) begin
            r = $urandom_range(0, 3);
            p[r]           = band_sample(SPEED_SLOW);
            p[(r + 1) % 4] = band_sample(SPEED_MID);
            p[(r + 2) % 4] = band_sample(SPEED_FAST);
        end else if (kind >= 80 && kind < 88) begin
            p[$urandom_range(0, 3)] = band_sample(SPEED_NONE);
        end
        case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = '1;
            default: count = 48'({$urandom(), $urandom()});
        endcase
        case ($urandom_range(0, 7))
            0:       cur = '0;
            1:       cur = '1;
            2:       cur = p[0];
            3:       cur = p[0] - 16'd1;
            4, 5:    cur = 16'($urandom_range(0, 28565));
            default: cur = 16'($urandom());
        endcase
        if (kind >= 88) return {$urandom(), $urandom(), $urandom(), $urandom()};
        return {count, cur, p[3], p[2], p[1], p[0]};
    endfunction

    // one snapshot transfer; the expectation is queued on acceptance
    task automatic send_snapshot(input logic [63:0] lo_word, input logic [63:0] hi_word);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi_word, lo_word};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_decodes.push_back(decode_snapshot(lo_word, hi_word));
        snapshots_sent++;
    endtask

    // stop sending and let the pipeline empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        // only the register's own width is kept
        if (idx == CFG_CHECK_ENABLE) cfg_check = value[0];
        else cfg_unit = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic check, input logic [1:0] unit);
        drain_results();
        write_reg(CFG_CHECK_ENABLE, {1'b0, check});
        write_reg(CFG_TIME_UNIT, unit);
        config_phases++;
    endtask

    // reset values: checking on, nanoseconds
    task automatic test_reset_state();
        send_snapshot(history(25000, 25000, 25000, 25000),
                      high_word(48'h1234_5678_9ABC, 16'd12000));
        send_snapshot(history(25000, 18000, 12000, 25000),
                      high_word(48'h0000_0000_1000, 16'd500));
    endtask

    // band limits are open, and the three two-band pairs
    task automatic test_band_edges();
        configure(1'b1, UNIT_US);
        send_snapshot(history(BAND_FAST_LO + 16'd1, BAND_FAST_HI - 16'd1,
                              BAND_FAST_LO + 16'd1, BAND_FAST_HI - 16'd1),
                      high_word(48'd1000, 16'd24000));
        send_snapshot(history(BAND_MID_LO + 16'd1, BAND_MID_HI - 16'd1,
                              BAND_SLOW_LO + 16'd1, BAND_SLOW_HI - 16'd1),
                      high_word(48'd77, 16'd9000));
        send_snapshot(history(BAND_FAST_LO, 25000, 25000, 25000), high_word(48'd5, 16'd100));
        send_snapshot(history(25000, BAND_MID_HI, 18000, 18000), high_word(48'd5, 16'd100));
        send_snapshot(history(BAND_SLOW_LO, 12000, 12000, 12000), high_word(48'd5, 16'd100));
        send_snapshot(history(25000, 25000, 25000, BAND_FAST_HI), high_word(48'd5, 16'd100));
        send_snapshot(history(25000, 12000, 25000, 12000), high_word(48'd9, 16'd3000));
        send_snapshot(history(25000, 18000, 18000, 25000), high_word(48'd9, 16'd3000));
    endtask

    // fraction corner cases without the band check
    task automatic test_fraction_extremes();
        configure(1'b0, UNIT_NS);
        send_snapshot('0, '0);
        send_snapshot('1, '1);
        // all periods zero: divisor clamps to one, fraction saturates
        send_snapshot('0, high_word(48'd3, 16'hFFFF));
        send_snapshot(history(25000, 25000, 25000, 25000), high_word('1, 16'd24999));
        // current equal to the largest period saturates
        send_snapshot(history(25000, 20000, 24000, 25000), high_word(48'd42, 16'd25000));
        send_snapshot(history(25000, 25000, 25000, 25000), high_word(48'd42, 16'd0));
    endtask

    // largest tick value under every unit code, the unused one too
    task automatic test_units();
        configure(1'b0, UNIT_NS);
        send_snapshot('0, '1);
        configure(1'b0, UNIT_US);
        send_snapshot('0, '1);
        configure(1'b0, UNIT_MS);
        send_snapshot('0, '1);
        configure(1'b0, UNIT_NONE);
        send_snapshot('0, '1);
    endtask

    // upper data bit must not reach the one-bit check register
    task automatic test_register_width();
        drain_results();
        write_reg(CFG_TIME_UNIT, UNIT_MS);
        write_reg(CFG_CHECK_ENABLE, 2'b10);
        send_snapshot(history(25000, 18000, 12000, 30000), high_word(48'd123456, 16'd8000));
        drain_results();
        write_reg(CFG_CHECK_ENABLE, 2'b11);
        send_snapshot(history(25000, 18000, 12000, 30000), high_word(48'd123456, 16'd8000));
    endtask

    // random phases; each phase has a burst stretch with no gaps or stalls
    task automatic test_random_decodes();
        logic [127:0] snap;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       configure(1'b1, UNIT_NS);
                1:       configure(1'b0, UNIT_MS);
                2:       configure(1'b1, UNIT_NONE);
                3:       configure(1'b0, UNIT_US);
                default: configure(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                no_idle = ((i / 30) % 4) == 3;
                snap = random_snapshot();
                send_snapshot(snap[63:0], snap[127:64]);
            end
            no_idle = 1'b0;
        end
    endtask

    // result side: random stall before each transfer
    initial begin : result_ready
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_decode want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_decodes.size() == 0) begin
                mismatch_count++;
                $display("%0t result with nothing expected: expected none, got %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_decodes.pop_front();
                results_checked++;
                if (m_axis_tdata[63:0] !== want.ticks) begin
                    mismatch_count++;
                    $display("%0t ticks_fixed: expected %h, got %h",
                             $time, want.ticks, m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[126:64] !== want.scaled) begin
                    mismatch_count++;
                    $display("%0t time_value: expected %h, got %h",
                             $time, want.scaled, m_axis_tdata[126:64]);
                end
                if (m_axis_tdata[127] !== 1'b0) begin
                    mismatch_count++;
                    $display("%0t pad bit: expected 0, got %b", $time, m_axis_tdata[127]);
                end
                if (m_axis_tuser !== want.valid) begin
                    mismatch_count++;
                    $display("%0t history_valid: expected %b, got %b",
                             $time, want.valid, m_axis_tuser);
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_CHECK_ENABLE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        // registers come out of reset checked, in nanoseconds
        cfg_check = 1'b1;
        cfg_unit  = UNIT_NS;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_band_edges();
        test_fraction_extremes();
        test_units();
        test_register_width();
        test_random_decodes();
        drain_results();

        $display("sent %0d snapshots over %0d register settings, checked %0d decodes",
                 snapshots_sent, config_phases, results_checked);
        $display("band edges, saturated fractions, all unit codes and random gaps covered");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
